FILE: hdl/clnib_pkg.sv
package clnib_pkg;

  // action codes
  localparam logic [3:0] ACT_INIT  = 4'd0;
  localparam logic [3:0] ACT_CMD   = 4'd1;
  localparam logic [3:0] ACT_DATA  = 4'd2;
  localparam logic [3:0] ACT_GOTO  = 4'd3;
  localparam logic [3:0] ACT_HOME  = 4'd4;
  localparam logic [3:0] ACT_CLEAR = 4'd5;
  localparam logic [3:0] ACT_PUT   = 4'd6;
  localparam logic [3:0] ACT_PUTAT = 4'd7;
  localparam logic [3:0] ACT_READ  = 4'd8;

  // job kinds handed from front to back
  localparam logic [1:0] JOB_INIT = 2'd0;
  localparam logic [1:0] JOB_BYTE = 2'd1;
  localparam logic [1:0] JOB_READ = 2'd2;

  localparam logic [7:0]  SET_ADDR_CMD = 8'h80;
  localparam logic [7:0]  CLEAR_CMD    = 8'h01;
  localparam logic [7:0]  ROW1_BASE    = 8'h40;
  localparam logic [7:0]  SPACE_CHAR   = 8'h20;
  localparam logic [15:0] BYTE_WAIT_US = 16'd100;
  localparam logic [3:0]  INIT_LAST    = 4'd11;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] byte_value;
    logic [1:0] target_row;
    logic [4:0] target_col;
  } in_item_t;

  typedef struct packed {
    logic        is_strobe;
    logic        register_select;
    logic [3:0]  nibble;
    logic [15:0] wait_before_us;
    logic [7:0]  cell_value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       rs;
    logic [7:0] data;
    logic       last;
  } job_t;

  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] n;
    unique case (idx) inside
      4'd0, 4'd1, 4'd2:           n = 4'h3;
      4'd3, 4'd4:                 n = 4'h2;
      4'd5, 4'd7:                 n = 4'h8;
      4'd9:                       n = 4'h1;
      4'd11:                      n = 4'hC;
      default:                    n = 4'h0;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] init_wait(input logic [3:0] idx);
    logic [15:0] w;
    unique case (idx) inside
      4'd0:       w = 16'd50000;
      4'd1, 4'd2: w = 16'd5000;
      default:    w = 16'd2000;
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/clnib_ram.sv
module clnib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/clnib_queue.sv
module clnib_queue
  import clnib_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  job_t              push_job,
  input  logic              pop,
  output job_t              head_job,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_job = slot_r[rd_ptr_r];
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;

endmodule

FILE: hdl/clnib_front.sv
module clnib_front
  import clnib_pkg::*;
#(
  parameter int ROWS = 2,
  parameter int COLS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  in_item_t          in_item,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output job_t              q_job
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam logic [1:0] ST_BOOT   = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SECOND = 2'd2;
  localparam logic [1:0] ST_READ   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       cur_row_r, cur_row_nxt;
  logic [4:0]       cur_col_r, cur_col_nxt;
  logic [CELLS-1:0] valid_r, valid_nxt;
  logic             fill_r, fill_nxt;
  job_t             second_r, second_nxt;
  logic             rd_hit_r, rd_hit_nxt;
  logic             rd_vld_r, rd_vld_nxt;

  logic          accept;
  logic          tgt_in, cur_in;
  logic [AW-1:0] tgt_addr, cur_addr;
  logic [6:0]    tgt_sum, cur_sum;
  logic [7:0]    goto_cmd;
  logic [5:0]    col_inc;
  logic [2:0]    row_inc;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    rd_value;

  assign accept = in_push && !in_full;
  assign in_full = (state_r != ST_IDLE) || (q_count > QCNT_W'(QDEPTH - 2));

  assign tgt_in   = (32'(in_item.target_row) < ROWS) && (32'(in_item.target_col) < COLS);
  assign cur_in   = (32'(cur_row_r) < ROWS) && (32'(cur_col_r) < COLS);
  assign tgt_sum  = {2'b00, in_item.target_col} + (in_item.target_row[0] ? 7'(COLS) : 7'd0);
  assign cur_sum  = {2'b00, cur_col_r} + (cur_row_r[0] ? 7'(COLS) : 7'd0);
  assign tgt_addr = AW'(tgt_sum);
  assign cur_addr = AW'(cur_sum);

  always_comb begin
    unique case (in_item.target_row)
      2'd0:    goto_cmd = SET_ADDR_CMD | {3'b000, in_item.target_col};
      2'd1:    goto_cmd = SET_ADDR_CMD | (ROW1_BASE + {3'b000, in_item.target_col});
      default: goto_cmd = SET_ADDR_CMD;
    endcase
  end

  assign col_inc = {1'b0, cur_col_r} + 6'd1;
  assign row_inc = {1'b0, cur_row_r} + 3'd1;

  clnib_ram #(
    .WIDTH (8),
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.byte_value),
    .raddr (tgt_addr),
    .rdata (ram_rdata)
  );

  // cells never written since a clear read as the fill character; before the first clear they read as 00
  assign rd_value = !rd_hit_r ? 8'h00 :
                    rd_vld_r  ? ram_rdata :
                    fill_r    ? SPACE_CHAR : 8'h00;

  always_comb begin
    state_nxt   = state_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    valid_nxt   = valid_r;
    fill_nxt    = fill_r;
    second_nxt  = second_r;
    rd_hit_nxt  = rd_hit_r;
    rd_vld_nxt  = rd_vld_r;
    ram_we      = 1'b0;
    ram_waddr   = tgt_addr;
    q_push      = 1'b0;
    q_job       = '{kind: JOB_BYTE, rs: 1'b0, data: 8'h00, last: 1'b1};

    unique case (state_r)
      ST_BOOT: begin
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.action)
            ACT_INIT: begin
              q_push     = 1'b1;
              q_job.kind = JOB_INIT;
            end
            ACT_CMD: begin
              q_push     = 1'b1;
              q_job.data = in_item.byte_value;
            end
            ACT_DATA: begin
              q_push     = 1'b1;
              q_job.rs   = 1'b1;
              q_job.data = in_item.byte_value;
            end
            ACT_GOTO: begin
              q_push      = 1'b1;
              q_job.data  = goto_cmd;
              cur_row_nxt = in_item.target_row;
              cur_col_nxt = in_item.target_col;
            end
            ACT_HOME: begin
              q_push      = 1'b1;
              q_job.data  = SET_ADDR_CMD;
              cur_row_nxt = 2'd0;
              cur_col_nxt = 5'd0;
            end
            ACT_CLEAR: begin
              q_push      = 1'b1;
              q_job.data  = CLEAR_CMD;
              q_job.last  = 1'b0;
              second_nxt  = '{kind: JOB_BYTE, rs: 1'b0, data: SET_ADDR_CMD, last: 1'b1};
              state_nxt   = ST_SECOND;
              valid_nxt   = '0;
              fill_nxt    = 1'b1;
              cur_row_nxt = 2'd0;
              cur_col_nxt = 5'd0;
            end
            ACT_PUT: begin
              if (cur_in) begin
                ram_we              = 1'b1;
                ram_waddr           = cur_addr;
                valid_nxt[cur_addr] = 1'b1;
              end
              if (32'(col_inc) >= COLS) begin
                cur_col_nxt = 5'd0;
                cur_row_nxt = (32'(row_inc) >= ROWS) ? 2'd0 : row_inc[1:0];
              end else begin
                cur_col_nxt = col_inc[4:0];
              end
            end
            ACT_PUTAT: begin
              if (tgt_in) begin
                q_push              = 1'b1;
                q_job.data          = goto_cmd;
                q_job.last          = 1'b0;
                second_nxt          = '{kind: JOB_BYTE, rs: 1'b1,
                                        data: in_item.byte_value, last: 1'b1};
                state_nxt           = ST_SECOND;
                ram_we              = 1'b1;
                valid_nxt[tgt_addr] = 1'b1;
                cur_row_nxt         = in_item.target_row;
                cur_col_nxt         = in_item.target_col;
              end
            end
            ACT_READ: begin
              rd_hit_nxt = tgt_in;
              rd_vld_nxt = valid_r[tgt_addr];
              state_nxt  = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SECOND: begin
        q_push    = 1'b1;
        q_job     = second_r;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        q_push    = 1'b1;
        q_job     = '{kind: JOB_READ, rs: 1'b0, data: rd_value, last: 1'b1};
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_BOOT;
      cur_row_r <= '0;
      cur_col_r <= '0;
      valid_r   <= '0;
      fill_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      valid_r   <= valid_nxt;
      fill_r    <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    second_r <= second_nxt;
    rd_hit_r <= rd_hit_nxt;
    rd_vld_r <= rd_vld_nxt;
  end

endmodule

FILE: hdl/clnib_back.sv
module clnib_back
  import clnib_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_head,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  job_t      job_r, job_nxt;
  logic      busy_r, busy_nxt;
  logic [3:0] step_r, step_nxt;
  out_item_t res_r, res_nxt;
  logic      res_vld_r, res_vld_nxt;

  logic      produce;
  logic      final_step;
  out_item_t gen;

  assign produce = busy_r && (!res_vld_r || out_pop);
  assign q_pop   = !busy_r && !q_empty;

  always_comb begin
    gen        = '0;
    final_step = 1'b1;
    unique case (job_r.kind)
      JOB_INIT: begin
        gen.is_strobe      = 1'b1;
        gen.nibble         = init_nibble(step_r);
        gen.wait_before_us = init_wait(step_r);
        final_step         = (step_r == INIT_LAST);
      end
      JOB_BYTE: begin
        gen.is_strobe       = 1'b1;
        gen.register_select = job_r.rs;
        // high nibble first, low nibble follows with no wait
        gen.nibble          = (step_r == 4'd0) ? job_r.data[7:4] : job_r.data[3:0];
        gen.wait_before_us  = (step_r == 4'd0) ? BYTE_WAIT_US : 16'd0;
        final_step          = (step_r != 4'd0);
      end
      default: begin
        gen.cell_value = job_r.data;
      end
    endcase
    gen.last = job_r.last && final_step;
  end

  always_comb begin
    job_nxt     = job_r;
    busy_nxt    = busy_r;
    step_nxt    = step_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r && !out_pop;
    if (q_pop) begin
      job_nxt  = q_head;
      busy_nxt = 1'b1;
      step_nxt = 4'd0;
    end
    if (produce) begin
      res_nxt     = gen;
      res_vld_nxt = 1'b1;
      step_nxt    = step_r + 4'd1;
      if (final_step) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    step_r <= step_nxt;
    res_r  <= res_nxt;
  end

  assign out_empty = !res_vld_r;
  assign out_item  = res_r;

endmodule

FILE: hdl/char_lcd_nibble_interface.sv
// channel  | ports                        | moves
// ---------+------------------------------+-------------------------------------
// input    | in_push, in_full, in_item    | one action per transaction
// result   | out_pop, out_empty, out_item | one nibble strobe or cell answer
//
// the front takes an action; clear, on-screen put at and cell read add a second
// state (second job push, or the registered buffer read); the back loads a job
// and emits one result a cycle while no unpopped result is held
// a 4-entry job queue splits front and back, so either side stalls on its own
// in_full is high for the first cycle after reset and while the queue is nearly full
// reset is synchronous; the shadow buffer needs no clearing pass after reset
module char_lcd_nibble_interface
  import clnib_pkg::*;
#(
  parameter int ROWS = 2,
  parameter int COLS = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;
  job_t              q_job;
  job_t              q_head;

  clnib_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_count (q_count),
    .q_push  (q_push),
    .q_job   (q_job)
  );

  clnib_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (q_head),
    .empty    (q_empty),
    .count    (q_count)
  );

  clnib_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count != QCNT_W'(QDEPTH)))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job queue underflow");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(q_push) && !$past(q_pop) |-> q_count == $past(q_count) + 1'b1)
    else $error("job queue count lost a push");

endmodule

FILE: sim/char_lcd_nibble_interface_tb.sv
module char_lcd_nibble_interface_tb;
  import clnib_pkg::*;

  localparam int ROWS = 2;
  localparam int COLS = 20;
  localparam int RANDOM_ITEMS = 330;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int LONG_HOLD_AFTER = 80;

  // power-up nibbles, first one in the top bits
  localparam logic [47:0] POWER_UP_NIBBLES = 48'h3332_2808_010C;

  class lcd_bus_scoreboard;
    out_item_t predicted_traffic[$];
    out_item_t action_results[$];
    logic [7:0] shadow[ROWS*COLS];
    logic [1:0] cur_row;
    logic [4:0] cur_col;
    int errors;
    int strobes_checked;
    int reads_checked;
    int results_checked;
    int action_seen[16];

    function new();
      foreach (shadow[i]) shadow[i] = 8'h00;
      cur_row = '0;
      cur_col = '0;
      errors = 0;
      strobes_checked = 0;
      reads_checked = 0;
      results_checked = 0;
      foreach (action_seen[i]) action_seen[i] = 0;
    endfunction

    function int outstanding();
      return predicted_traffic.size();
    endfunction

    function bit on_screen(int r, int c);
      return r < ROWS && c < COLS;
    endfunction

    function void add_strobe(logic rs, logic [3:0] nib, logic [15:0] delay_us);
      out_item_t s;
      s = '0;
      s.is_strobe = 1'b1;
      s.register_select = rs;
      s.nibble = nib;
      s.wait_before_us = delay_us;
      action_results.push_back(s);
    endfunction

    function void send_byte(logic rs, logic [7:0] b);
      add_strobe(rs, b[7:4], BYTE_WAIT_US);
      add_strobe(rs, b[3:0], 16'd0);
    endfunction

    function void go_to(logic [1:0] r, logic [4:0] c);
      logic [7:0] addr;
      if (r == 2'd0) addr = {3'b000, c};
      else if (r == 2'd1) addr = ROW1_BASE + {3'b000, c};
      else addr = 8'h00;
      send_byte(1'b0, SET_ADDR_CMD | addr);
      cur_row = r;
      cur_col = c;
    endfunction

    function void note_action(in_item_t a);
      out_item_t answer;
      action_results.delete();
      action_seen[a.action]++;
      case (a.action)
        ACT_INIT: begin
          for (int i = 0; i < 12; i++)
            add_strobe(1'b0, POWER_UP_NIBBLES[47-4*i -: 4],
                       (i == 0) ? 16'd50000 : (i < 3) ? 16'd5000 : 16'd2000);
        end
        ACT_CMD: send_byte(1'b0, a.byte_value);
        ACT_DATA: send_byte(1'b1, a.byte_value);
        ACT_GOTO: go_to(a.target_row, a.target_col);
        ACT_HOME: go_to(2'd0, 5'd0);
        ACT_CLEAR: begin
          foreach (shadow[i]) shadow[i] = SPACE_CHAR;
          send_byte(1'b0, CLEAR_CMD);
          go_to(2'd0, 5'd0);
        end
        ACT_PUT: begin
          if (on_screen(cur_row, cur_col)) shadow[int'(cur_row)*COLS + int'(cur_col)] = a.byte_value;
          // cursor steps right, wrapping to the next row and back to the top
          if (int'(cur_col) + 1 >= COLS) begin
            cur_col = 5'd0;
            cur_row = (int'(cur_row) + 1 >= ROWS) ? 2'd0 : cur_row + 2'd1;
          end else begin
            cur_col = cur_col + 5'd1;
          end
        end
        ACT_PUTAT: begin
          if (on_screen(a.target_row, a.target_col)) begin
            go_to(a.target_row, a.target_col);
            send_byte(1'b1, a.byte_value);
            shadow[int'(a.target_row)*COLS + int'(a.target_col)] = a.byte_value;
          end
        end
        ACT_READ: begin
          answer = '0;
          if (on_screen(a.target_row, a.target_col))
            answer.cell_value = shadow[int'(a.target_row)*COLS + int'(a.target_col)];
          action_results.push_back(answer);
        end
        default: ;
      endcase
      if (action_results.size() > 0) action_results[action_results.size()-1].last = 1'b1;
      foreach (action_results[i]) predicted_traffic.push_back(action_results[i]);
    endfunction

    task compare_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        errors++;
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (predicted_traffic.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = predicted_traffic.pop_front();
        if (want.is_strobe) strobes_checked++;
        else reads_checked++;
        compare_field("is_strobe", want.is_strobe, got.is_strobe);
        compare_field("register_select", want.register_select, got.register_select);
        compare_field("nibble", want.nibble, got.nibble);
        compare_field("wait_before_us", want.wait_before_us, got.wait_before_us);
        compare_field("cell_value", want.cell_value, got.cell_value);
        compare_field("last", want.last, got.last);
      end
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  lcd_bus_scoreboard sb = new();
  int cycle_count;
  int items_sent;
  int sender_steady;
  bit long_hold_done;

  char_lcd_nibble_interface #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_item(in_item),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.outstanding());
      $display("Test completed with failures");
      $finish;
    end
  end

  // monitor: both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) sb.check_result(out_item);
      if (in_push && !in_full) sb.note_action(in_item);
    end
  end

  function automatic in_item_t make_action(logic [3:0] act, logic [7:0] b,
                                           logic [1:0] r, logic [4:0] c);
    in_item_t a;
    a.action = act;
    a.byte_value = b;
    a.target_row = r;
    a.target_col = c;
    return a;
  endfunction

  task automatic send_action(in_item_t a);
    @(negedge clk);
    in_push <= 1'b1;
    in_item <= a;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  task automatic sender_pause();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (sender_steady > 0) begin
      sender_steady--;
      gap = 0;
    end else if (r < 5) begin
      sender_steady = $urandom_range(15, 50);
      gap = 0;
    end else if (r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(30, 80);
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [1:0] pick_row();
    return ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
  endfunction

  function automatic logic [4:0] pick_col();
    return ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, COLS - 1))
                                        : 5'($urandom_range(COLS, 31));
  endfunction

  function automatic in_item_t random_action();
    int r;
    logic [3:0] act;
    r = $urandom_range(0, 99);
    if (r < 3) act = ACT_INIT;
    else if (r < 8) act = ACT_CMD;
    else if (r < 13) act = ACT_DATA;
    else if (r < 23) act = ACT_GOTO;
    else if (r < 27) act = ACT_HOME;
    else if (r < 30) act = ACT_CLEAR;
    else if (r < 55) act = ACT_PUT;
    else if (r < 75) act = ACT_PUTAT;
    else if (r < 96) act = ACT_READ;
    else act = 4'($urandom_range(9, 15));
    return make_action(act, 8'($urandom), pick_row(), pick_col());
  endfunction

  // receiver: random pop stalls plus one long hold-off that backs up the block
  initial begin
    int r;
    int stall_left;
    int run_left;
    out_pop = 1'b0;
    stall_left = 0;
    run_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_hold_done && sb.results_checked >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_pop <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_pop <= 1'b1;
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          out_pop <= 1'b1;
          run_left = $urandom_range(20, 60);
        end else if (r < 75) begin
          out_pop <= 1'b1;
        end else begin
          out_pop <= 1'b0;
          stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(15, 45);
        end
      end
    end
  end

  initial begin
    int n;
    int cells_written;
    logic [1:0] r0;
    logic [4:0] c0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    cycle_count = 0;
    items_sent = 0;
    sender_steady = 0;
    long_hold_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    send_action(make_action(ACT_INIT, 8'h00, 2'd0, 5'd0));
    send_action(make_action(ACT_CMD, 8'h00, 2'd3, 5'd31));
    send_action(make_action(ACT_CMD, 8'hFF, 2'd0, 5'd0));
    send_action(make_action(ACT_DATA, 8'h5A, 2'd1, 5'd10));
    send_action(make_action(ACT_READ, 8'hFF, 2'd0, 5'd0));
    send_action(make_action(ACT_CLEAR, 8'h00, 2'd0, 5'd0));
    send_action(make_action(ACT_READ, 8'h00, 2'd1, 5'd19));
    send_action(make_action(ACT_GOTO, 8'h00, 2'd1, 5'd31));
    send_action(make_action(ACT_GOTO, 8'h00, 2'd2, 5'd7));
    // cursor parked off the screen, put wraps it back to the top
    send_action(make_action(ACT_GOTO, 8'h00, 2'd3, 5'd30));
    send_action(make_action(ACT_PUT, 8'hAA, 2'd0, 5'd0));
    send_action(make_action(ACT_PUT, 8'hFF, 2'd0, 5'd0));
    send_action(make_action(ACT_GOTO, 8'h00, 2'd0, 5'd19));
    send_action(make_action(ACT_PUT, 8'h01, 2'd0, 5'd0));
    send_action(make_action(ACT_GOTO, 8'h00, 2'd1, 5'd19));
    send_action(make_action(ACT_PUT, 8'h80, 2'd0, 5'd0));
    send_action(make_action(ACT_PUTAT, 8'h00, 2'd0, 5'd0));
    send_action(make_action(ACT_PUTAT, 8'h7E, 2'd1, 5'd19));
    send_action(make_action(ACT_PUTAT, 8'h33, 2'd2, 5'd4));
    send_action(make_action(ACT_PUTAT, 8'h44, 2'd0, 5'd20));
    send_action(make_action(ACT_PUTAT, 8'h55, 2'd1, 5'd31));
    send_action(make_action(ACT_READ, 8'h00, 2'd1, 5'd19));
    send_action(make_action(ACT_READ, 8'h00, 2'd0, 5'd19));
    send_action(make_action(ACT_READ, 8'h00, 2'd2, 5'd3));
    send_action(make_action(ACT_READ, 8'h00, 2'd0, 5'd25));
    send_action(make_action(ACT_HOME, 8'hC3, 2'd3, 5'd17));
    send_action(make_action(4'd9, 8'h12, 2'd1, 5'd1));
    send_action(make_action(4'd15, 8'hFF, 2'd3, 5'd31));
    wait_for_drain();

    // random part: line writes through the cursor in 30 percent of rounds, else single actions
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + 3) wait_for_drain();
      if ($urandom_range(0, 99) < 30) begin
        r0 = pick_row();
        c0 = pick_col();
        send_action(make_action(ACT_GOTO, 8'($urandom), r0, c0));
        sender_pause();
        cells_written = $urandom_range(3, 25);
        for (n = 0; n < cells_written; n++) begin
          send_action(make_action(ACT_PUT, 8'($urandom), 2'($urandom), 5'($urandom)));
          sender_pause();
        end
        n = $urandom_range(1, 3);
        repeat (n) begin
          send_action(make_action(ACT_READ, 8'($urandom), r0, 5'($urandom_range(0, COLS - 1))));
          sender_pause();
        end
      end else begin
        send_action(random_action());
        sender_pause();
      end
    end

    wait_for_drain();
    repeat (40) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
      sb.errors++;
    end
    $display("run covered %0d inits, %0d clears, %0d buffered puts, %0d put-at, %0d reads",
             sb.action_seen[ACT_INIT], sb.action_seen[ACT_CLEAR], sb.action_seen[ACT_PUT],
             sb.action_seen[ACT_PUTAT], sb.action_seen[ACT_READ]);
    $display("checked %0d bus strobes and %0d cell answers, %0d errors",
             sb.strobes_checked, sb.reads_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/clnib_pkg.sv
hdl/clnib_ram.sv
hdl/clnib_queue.sv
hdl/clnib_front.sv
hdl/clnib_back.sv
hdl/char_lcd_nibble_interface.sv
sim/char_lcd_nibble_interface_tb.sv
